// ----- sv/sida_pkg.sv -----
// Shared types, constants and sizing function for the signed integer to
// decimal ASCII converter. No dependencies.
package sida_pkg;

	localparam int VALUE_BITS_DEF = 32;

	localparam logic [5:0] CHAR_MINUS = 6'd45;
	localparam logic [5:0] CHAR_ZERO  = 6'd48;

	// controller -> datapath
	typedef struct packed {
		logic load;
		logic step;
		logic emit_sign;
		logic emit_digit;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic out_free;
		logic negative;
		logic last_digit;
	} stat_t;

	// Decimal digit count of 2^(bits-1), the largest magnitude.
	function automatic int max_digits(input int bits);
		longint unsigned p;
		int n;
		p = 64'd1 << (bits - 1);
		n = 0;
		while (p != 64'd0) begin
			p = p / 64'd10;
			n++;
		end
		return n;
	endfunction

endpackage

// ----- sv/signed_int_to_decimal_ascii.sv -----
// Top level of the signed integer to decimal ASCII converter: controller
// plus datapath. Depends on sida_pkg, sida_ctrl and sida_dp.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+-----------------------------------
//  s_      | in  | s_tvalid/s_tready  | s_tdata: value (VALUE_BITS, signed)
//  m_      | out | m_tvalid/m_tready  | m_tdata: text_char [5:0]; m_tlast: is_last
//
//  One number is accepted, then taken through the shift-add-3 steps (one bit
//  of the magnitude per cycle through the BCD register), then written out one
//  character at a time through the output register, as the receiver takes them.
//  s_tready is high only while the sequencer is idle; a finished character
//  waits in the output register, so the next word is taken meanwhile.
//  Reset clears the sequencer and the output valid flag; no clearing pass.
//  Output stalls hold the sequencer in its sign or digit state.
module signed_int_to_decimal_ascii #(
	parameter int VALUE_BITS = sida_pkg::VALUE_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [((VALUE_BITS+7)/8)*8-1:0]     s_tdata,  // [VALUE_BITS-1:0] value
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [7:0]                          m_tdata,  // [5:0] text_char
	output logic                                m_tlast
);

	sida_pkg::cmd_t  cmd;
	sida_pkg::stat_t stat;
	logic [5:0]      text_char;

	sida_ctrl #(.VALUE_BITS(VALUE_BITS)) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// upper padding bits of s_tdata are ignored
	sida_dp #(.VALUE_BITS(VALUE_BITS)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.value     (s_tdata[VALUE_BITS-1:0]),
		.cmd       (cmd),
		.stat      (stat),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.text_char (text_char),
		.is_last   (m_tlast)
	);

	assign m_tdata = {2'b00, text_char};

`ifndef SYNTHESIS
	// never overwrite a character still waiting in the output register
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_sign || cmd.emit_digit) |-> stat.out_free)
		else $error("character emitted into occupied output register");

	// commands are mutually exclusive
	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.step, cmd.emit_sign, cmd.emit_digit}))
		else $error("more than one datapath command");

	// only a minus sign or a decimal digit leaves the block
	a_char_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata == 8'd45 || (m_tdata >= 8'd48 && m_tdata <= 8'd57)))
		else $error("output character out of range");

	// the units digit closes the number
	a_last_digit: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_digit && stat.last_digit) |=> (m_tvalid && m_tlast))
		else $error("last digit not marked with m_tlast");

	// a minus sign is never the last character
	a_sign_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_sign |=> (m_tvalid && !m_tlast && m_tdata == 8'd45))
		else $error("minus sign malformed");
`endif

endmodule

// ----- sv/sida_ctrl.sv -----
// Sequencer for the converter: accept, shift-add-3 steps, sign, digits.
// Depends on sida_pkg.
module sida_ctrl #(
	parameter int VALUE_BITS = sida_pkg::VALUE_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  sida_pkg::stat_t  stat,
	output sida_pkg::cmd_t   cmd
);

	localparam int CW = $clog2(VALUE_BITS + 1);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_CONV = 2'd1;
	localparam logic [1:0] S_SIGN = 2'd2;
	localparam logic [1:0] S_DIG  = 2'd3;

	logic [1:0]    state_q, state_d;
	logic [CW-1:0] cnt_q, cnt_d;

	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		cmd      = '0;
		s_tready = 1'b0;
		case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load = 1'b1;
					cnt_d    = CW'(VALUE_BITS);
					state_d  = S_CONV;
				end
			end
			S_CONV: begin
				cmd.step = 1'b1;
				cnt_d    = cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					state_d = stat.negative ? S_SIGN : S_DIG;
				end
			end
			S_SIGN: begin
				if (stat.out_free) begin
					cmd.emit_sign = 1'b1;
					state_d       = S_DIG;
				end
			end
			S_DIG: begin
				if (stat.out_free) begin
					cmd.emit_digit = 1'b1;
					if (stat.last_digit) begin
						state_d = S_IDLE;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

endmodule

// ----- sv/sida_dp.sv -----
// Datapath: magnitude shifter, BCD digit register, digit pointer and the
// output word register. Depends on sida_pkg.
module sida_dp #(
	parameter int VALUE_BITS = sida_pkg::VALUE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [VALUE_BITS-1:0] value,
	input  sida_pkg::cmd_t        cmd,
	output sida_pkg::stat_t       stat,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [5:0]            text_char,
	output logic                  is_last
);

	localparam int ND = sida_pkg::max_digits(VALUE_BITS);
	localparam int DW = (ND > 1) ? $clog2(ND) : 1;

	logic [VALUE_BITS-1:0] mag_q;
	logic                  neg_q;
	logic [ND-1:0][3:0]    bcd_q, bcd_adj, bcd_nx;
	logic [DW-1:0]         eidx_q, eidx_nx, nxt_idx;
	logic                  out_valid_q;
	logic [5:0]            char_q;
	logic                  last_q;

	// One shift-add-3 step: fix up every digit, then shift in the next bit.
	always_comb begin
		for (int i = 0; i < ND; i++) begin
			bcd_adj[i] = (bcd_q[i] >= 4'd5) ? (bcd_q[i] + 4'd3) : bcd_q[i];
		end
		bcd_nx[0] = {bcd_adj[0][2:0], mag_q[VALUE_BITS-1]};
		for (int i = 1; i < ND; i++) begin
			bcd_nx[i] = {bcd_adj[i][2:0], bcd_adj[i-1][3]};
		end
		// at most one new significant digit appears per step
		nxt_idx = eidx_q + 1'b1;
		eidx_nx = eidx_q;
		if (eidx_q != DW'(ND - 1)) begin
			if (bcd_nx[nxt_idx] != 4'd0) begin
				eidx_nx = nxt_idx;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			neg_q  <= value[VALUE_BITS-1];
			mag_q  <= value[VALUE_BITS-1] ? (~value + 1'b1) : value;
			bcd_q  <= '0;
			eidx_q <= '0;
		end else if (cmd.step) begin
			mag_q  <= {mag_q[VALUE_BITS-2:0], 1'b0};
			bcd_q  <= bcd_nx;
			eidx_q <= eidx_nx;
		end else if (cmd.emit_digit) begin
			eidx_q <= eidx_q - 1'b1;
		end
	end

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit_sign || cmd.emit_digit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_sign) begin
			char_q <= sida_pkg::CHAR_MINUS;
			last_q <= 1'b0;
		end else if (cmd.emit_digit) begin
			char_q <= sida_pkg::CHAR_ZERO + {2'b00, bcd_q[eidx_q]};
			last_q <= (eidx_q == '0);
		end
	end

	assign stat.out_free   = !out_valid_q || m_tready;
	assign stat.negative   = neg_q;
	assign stat.last_digit = (eidx_q == '0);

	assign m_tvalid  = out_valid_q;
	assign text_char = char_q;
	assign is_last   = last_q;

endmodule

// ----- test/signed_int_to_decimal_ascii_tb.sv -----
// Self-checking testbench for signed_int_to_decimal_ascii: drives 32-bit
// integers in, predicts their decimal ASCII text and checks each character.
// Depends on sida_pkg and the signed_int_to_decimal_ascii RTL.
module signed_int_to_decimal_ascii_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int BITS          = 32;
	localparam int MAX_DIGITS    = 10;    // digits of 2^31
	localparam int RESET_CYCLES  = 5;
	localparam int RANDOM_WORDS  = 88;
	localparam int SETTLE_CYCLES = 60;    // beyond the worst case per number
	localparam int STALL_LIMIT   = 3000;  // cycles with no word moving on either side
	localparam int LONG_HOLD     = 400;   // receiver hold-off that backs up the input
	localparam int HOLD_AFTER    = 40;    // input words taken before the hold-off starts

	// One expected character of the text.
	typedef struct packed {
		logic [5:0] code;
		logic       last;
	} text_char_t;

	// Predicts the decimal text of each accepted integer and checks the
	// characters that come out against it, oldest first.
	class decimal_text_board;
		text_char_t pending[$];
		int         errors;

		function new();
			errors = 0;
		endfunction

		// Spell the integer: optional minus sign, then digits without leading zeros.
		function void note_value(input logic [BITS-1:0] value);
			logic [BITS-1:0] mag;
			logic [3:0]      digits [0:MAX_DIGITS-1];
			int              count;
			int              k;
			text_char_t      c;
			// the most negative value negates onto itself, which is its
			// correct unsigned magnitude
			mag = value[BITS-1] ? (~value + 1'b1) : value;
			count = 0;
			do begin
				digits[count] = 4'(mag % 32'd10);
				count++;
				mag = mag / 32'd10;
			end while (mag != '0);
			if (value[BITS-1]) begin
				c.code = sida_pkg::CHAR_MINUS;
				c.last = 1'b0;
				pending.push_back(c);
			end
			for (k = count - 1; k >= 0; k--) begin
				c.code = sida_pkg::CHAR_ZERO + 6'(digits[k]);
				c.last = (k == 0);
				pending.push_back(c);
			end
		endfunction

		// Compare one output word with the oldest pending character.
		function void check_char(input logic [7:0] data, input logic last);
			text_char_t want;
			if (pending.size() == 0) begin
				$display("%0t: unexpected character: data=%0d last=%0b",
					$realtime, data, last);
				errors++;
				return;
			end
			want = pending.pop_front();
			if (data[5:0] !== want.code) begin
				$display("%0t: text_char mismatch: expected %0d actual %0d",
					$realtime, want.code, data[5:0]);
				errors++;
			end
			if (data[7:6] !== 2'b00) begin
				$display("%0t: tdata pad mismatch: expected 0 actual %0d",
					$realtime, data[7:6]);
				errors++;
			end
			if (last !== want.last) begin
				$display("%0t: is_last mismatch: expected %0b actual %0b",
					$realtime, want.last, last);
				errors++;
			end
		endfunction
	endclass

	logic            clk;
	logic            arst_n;
	logic            s_tvalid;
	logic            s_tready;
	logic [BITS-1:0] s_tdata;   // [31:0] value
	logic            m_tvalid;
	logic            m_tready;
	logic [7:0]      m_tdata;   // [5:0] text_char, [7:6] zero
	logic            m_tlast;   // is_last

	decimal_text_board board;
	int                words_in;
	int                quiet_cycles;

	signed_int_to_decimal_ascii #(
		.VALUE_BITS(BITS)
	) u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast)
	);

	// 12 ns clock period.
	initial clk = 1'b0;
	always #6 clk = ~clk;

	// Monitor: sample both handshakes at the rising edge, where the values
	// seen are the ones settled since the previous falling edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				board.note_value(s_tdata);
				words_in++;
			end
			if (m_tvalid && m_tready)
				board.check_char(m_tdata, m_tlast);
		end
	end

	// Watchdog: end the run if nothing moves on either side for too long.
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("%0t: watchdog expired with %0d characters pending",
				$realtime, board.pending.size());
			$display("signed_int_to_decimal_ascii_tb NOT OK");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Receiver: run through stretches of always-ready, light stalls and heavy
	// stalls, plus one long hold-off once the input side has seen some traffic,
	// so that the block backs up and drops s_tready while the sender offers.
	initial begin : receiver
		int mode;
		int left;
		bit held;
		mode = 0;
		left = 0;
		held = 1'b0;
		forever begin
			@(negedge clk);
			if (left == 0) begin
				if (!held && words_in >= HOLD_AFTER) begin
					held = 1'b1;
					mode = 3;
					left = LONG_HOLD;
				end else begin
					mode = $urandom_range(0, 2);
					left = $urandom_range(20, 200);
				end
			end
			left--;
			case (mode)
				0:       m_tready <= 1'b1;
				1:       m_tready <= ($urandom_range(0, 3) != 0);
				2:       m_tready <= ($urandom_range(0, 4) == 0);
				default: m_tready <= 1'b0;
			endcase
		end
	end

	// Offer one word and hold it until it is taken; valid stays high on return
	// so that a following word goes out back to back.
	task automatic send_word(input logic [BITS-1:0] value);
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= value;
		do @(posedge clk); while (!s_tready);
	endtask

	// Drop valid and idle the sender for the given number of cycles.
	task automatic idle_sender(input int cycles);
		@(negedge clk);
		s_tvalid <= 1'b0;
		s_tdata  <= $urandom;
		repeat (cycles - 1) @(negedge clk);
	endtask

	// Stop sending until every predicted character has come out.
	task automatic wait_text_drained();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (board.pending.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Random integer: mostly magnitudes of a random digit count so that every
	// text length shows up, sometimes around a power of ten, else raw bits.
	function automatic logic [BITS-1:0] pick_value();
		longint unsigned span;
		longint unsigned mag;
		int              digits;
		logic [BITS-1:0] value;
		digits = $urandom_range(1, MAX_DIGITS);
		span = 1;
		repeat (digits) span = span * 10;
		case ($urandom_range(0, 4))
			0: value = $urandom;
			1: begin
				mag = $urandom_range(0, 1) ? span : span - 1;
				value = mag[BITS-1:0];
			end
			default: begin
				mag = {$urandom, $urandom} % span;
				value = mag[BITS-1:0];
			end
		endcase
		if ($urandom_range(0, 1))
			value = -value;
		return value;
	endfunction

	initial begin : stimulus
		logic [BITS-1:0] corner [$];
		int sent;
		int burst;
		int gap;

		board    = new();
		words_in = 0;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		m_tready = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part: zero, single digits, powers of ten and their
		// neighbors, both extremes, the most negative value, alternating bits.
		corner = '{32'd0, 32'd1, -32'sd1, 32'd9, 32'd10, -32'sd10, 32'd99, 32'd100,
			32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001, 32'd1000000000,
			-32'sd1000000000, 32'd999999999, 32'd123456789, -32'sd987654321,
			32'h5555_5555, 32'hAAAA_AAAA, 32'd7, -32'sd5, 32'hFFFF_FFFF,
			32'd1073741824};
		foreach (corner[i])
			send_word(corner[i]);
		wait_text_drained();

		// Random part: bursts of words with random gaps, some gaps zero so
		// that words run back to back; drain fully once halfway.
		sent = 0;
		while (sent < RANDOM_WORDS) begin
			burst = $urandom_range(1, 10);
			repeat (burst) begin
				if (sent < RANDOM_WORDS) begin
					send_word(pick_value());
					sent++;
					if (sent == RANDOM_WORDS / 2)
						wait_text_drained();
				end
			end
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
			if (gap > 0)
				idle_sender(gap);
		end

		// Let the last characters out, then allow for stray output.
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (board.errors == 0)
			$display("signed_int_to_decimal_ascii_tb OK");
		else
			$display("signed_int_to_decimal_ascii_tb NOT OK");
		$finish;
	end

endmodule

// ----- files.f -----
sv/sida_pkg.sv
sv/sida_ctrl.sv
sv/sida_dp.sv
sv/signed_int_to_decimal_ascii.sv
test/signed_int_to_decimal_ascii_tb.sv
